FILE: sv/hteb_pkg.sv
package hteb_pkg;

   localparam int WORD_BITS = 32;
   localparam int SYMBOL_W  = 8;
   localparam int COUNT_W   = 6;
   localparam int FILL_W    = 5;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FLUSH  = 2'd2
   } action_type;

   // table entry as seen by the packer, zero extended to word width
   typedef struct packed {
      logic [WORD_BITS-1:0] code;
      logic [WORD_BITS-1:0] rev_code;
      logic [COUNT_W-1:0]   len;
   } entry_type;

endpackage

FILE: sv/hteb_code_table.sv
module hteb_code_table
   import hteb_pkg::*;
#(
   parameter int MAX_CODE_BITS = 32,
   parameter int SYMBOL_COUNT  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [SYMBOL_W-1:0]  wr_symbol,
   input  logic [WORD_BITS-1:0] wr_code,
   input  logic [COUNT_W-1:0]   wr_length,
   input  logic                 rd_en,
   input  logic [SYMBOL_W-1:0]  rd_symbol,
   output entry_type            rd_entry
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
   localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W + 1)'(SYMBOL_COUNT);
   localparam logic [COUNT_W-1:0] LEN_LIMIT = COUNT_W'(MAX_CODE_BITS);

   logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
   logic [MAX_CODE_BITS-1:0] rev_mem  [SYMBOL_COUNT];
   logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]  valid_ff;

   logic [WORD_BITS-1:0] rd_code_ff;
   logic [WORD_BITS-1:0] rd_rev_ff;
   logic [COUNT_W-1:0]   rd_len_ff;

   logic                 wr_in_range;
   logic                 rd_in_range;
   logic [IDX_W-1:0]     wr_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic [COUNT_W-1:0]   len_clamp;
   logic [WORD_BITS:0]   mask_wide;
   logic [WORD_BITS-1:0] code_masked;
   logic [WORD_BITS-1:0] rev_full;
   logic [WORD_BITS-1:0] rev_code;

   assign wr_in_range = {1'b0, wr_symbol} < SYM_LIMIT;
   assign rd_in_range = {1'b0, rd_symbol} < SYM_LIMIT;
   assign wr_idx      = wr_symbol[IDX_W-1:0];
   assign rd_idx      = rd_symbol[IDX_W-1:0];

   // overlong lengths saturate, bits above the length are dropped
   always_comb begin
      len_clamp   = (wr_length > LEN_LIMIT) ? LEN_LIMIT : wr_length;
      mask_wide   = ((WORD_BITS + 1)'(1) << len_clamp) - (WORD_BITS + 1)'(1);
      code_masked = wr_code & mask_wide[WORD_BITS-1:0];
      for (int i = 0; i < WORD_BITS; i++) begin
         rev_full[i] = code_masked[WORD_BITS-1-i];
      end
      // reversed code stays right aligned within its own length
      rev_code = rev_full >> (COUNT_W'(WORD_BITS) - len_clamp);
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         code_mem[wr_idx] <= code_masked[MAX_CODE_BITS-1:0];
         rev_mem[wr_idx]  <= rev_code[MAX_CODE_BITS-1:0];
         len_mem[wr_idx]  <= len_clamp[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_in_range) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_code_ff <= WORD_BITS'(code_mem[rd_idx]);
         rd_rev_ff  <= WORD_BITS'(rev_mem[rd_idx]);
         // never written or out of table reads as no code
         rd_len_ff  <= (rd_in_range && valid_ff[rd_idx]) ?
                       COUNT_W'(len_mem[rd_idx]) : '0;
      end
   end

   assign rd_entry = '{code: rd_code_ff, rev_code: rd_rev_ff, len: rd_len_ff};

endmodule

FILE: sv/huffman_table_encoder_bit_packer.sv
// Table-driven Huffman encoder with a 32-bit word packer. One request
// transaction can be taken every clock while the response side is not
// stalled; the table read is registered with the request, then the
// shift-and-merge result goes to the output register. Load, action-3 and
// non-filling encode requests with a code produce no response. The code
// table is empty after reset with no clearing pass (per-entry valid bits),
// so requests are accepted from the first cycle after reset. pack_order is
// written through csr_wr_en/csr_wr_data and takes effect on the next
// encode; it should only change while no transaction is in flight.
module huffman_table_encoder_bit_packer
   import hteb_pkg::*;
#(
   parameter int MAX_CODE_BITS = 32,
   parameter int SYMBOL_COUNT  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [SYMBOL_W-1:0]  req_symbol,
   input  logic [WORD_BITS-1:0] req_code_value,
   input  logic [COUNT_W-1:0]   req_code_length,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_packed_word,
   output logic [COUNT_W-1:0]   rsp_bit_count,
   output logic                 rsp_no_code_error,
   output logic                 rsp_last_word
);

   logic                 pack_order_ff;
   logic                 s1_valid_ff,  s1_valid_in;
   action_type           s1_action_ff, s1_action_in;
   logic [WORD_BITS-1:0] acc_ff,       acc_in;
   logic [FILL_W-1:0]    fill_ff,      fill_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_word_ff,  rsp_word_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_err_ff,   rsp_err_in;
   logic                 rsp_last_ff,  rsp_last_in;

   logic                 req_fire;
   logic                 s1_advance;
   action_type           req_act;
   entry_type            entry;
   logic [COUNT_W-1:0]   total;
   logic [COUNT_W:0]     msb_shift;
   logic [2*WORD_BITS-1:0] win_msb;
   logic [2*WORD_BITS-1:0] win_lsb;

   assign req_act    = action_type'(req_action);
   assign req_fire   = req_valid && req_ready;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   hteb_code_table #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .SYMBOL_COUNT  (SYMBOL_COUNT)
   ) u_code_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_fire && (req_act == ACT_LOAD)),
      .wr_symbol (req_symbol),
      .wr_code   (req_code_value),
      .wr_length (req_code_length),
      .rd_en     (req_fire && (req_act == ACT_ENCODE)),
      .rd_symbol (req_symbol),
      .rd_entry  (entry)
   );

   // two packing windows: msb-first keeps the word in the upper half,
   // lsb-first in the lower half
   always_comb begin
      total     = COUNT_W'(fill_ff) + entry.len;
      msb_shift = (COUNT_W + 1)'(2 * WORD_BITS) - (COUNT_W + 1)'(total);
      win_msb   = {acc_ff, {WORD_BITS{1'b0}}} |
                  ((2 * WORD_BITS)'(entry.code) << msb_shift);
      win_lsb   = (2 * WORD_BITS)'(acc_ff) |
                  ((2 * WORD_BITS)'(entry.rev_code) << fill_ff);
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_action_in = s1_action_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_action_in = req_act;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (s1_advance) begin
         case (s1_action_ff)
            ACT_ENCODE: begin
               if (entry.len == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '0;
                  rsp_count_in = '0;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b0;
               end else begin
                  fill_in = total[FILL_W-1:0];
                  if (total[FILL_W]) begin
                     // word filled: emit it, keep the spill
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = pack_order_ff ? win_lsb[WORD_BITS-1:0]
                                                  : win_msb[2*WORD_BITS-1:WORD_BITS];
                     rsp_count_in = COUNT_W'(WORD_BITS);
                     rsp_err_in   = 1'b0;
                     rsp_last_in  = 1'b0;
                     acc_in       = pack_order_ff ? win_lsb[2*WORD_BITS-1:WORD_BITS]
                                                  : win_msb[WORD_BITS-1:0];
                  end else begin
                     acc_in = pack_order_ff ? win_lsb[WORD_BITS-1:0]
                                            : win_msb[2*WORD_BITS-1:WORD_BITS];
                  end
               end
            end
            ACT_FLUSH: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = acc_ff;
               rsp_count_in = COUNT_W'(fill_ff);
               rsp_err_in   = 1'b0;
               rsp_last_in  = 1'b1;
               acc_in       = '0;
               fill_in      = '0;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_order_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s1_action_ff  <= ACT_LOAD;
         acc_ff        <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pack_order_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         s1_action_ff <= s1_action_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packed_word   = rsp_word_ff;
   assign rsp_bit_count     = rsp_count_ff;
   assign rsp_no_code_error = rsp_err_ff;
   assign rsp_last_word     = rsp_last_ff;

endmodule

FILE: sv/hteb_checker.sv
module hteb_checker
   import hteb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_packed_word,
   input logic [COUNT_W-1:0]   rsp_bit_count,
   input logic                 rsp_no_code_error,
   input logic                 rsp_last_word
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_word) &&
                                  $stable(rsp_bit_count) && $stable(rsp_last_word))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an error transaction carries no word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_code_error |->
         rsp_packed_word == '0 && rsp_bit_count == '0 && !rsp_last_word)
      else $error("error response carries data");

   // only a flush emits a partial word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_code_error && !rsp_last_word |->
         rsp_bit_count == COUNT_W'(WORD_BITS))
      else $error("full word response without full count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_bit_count < COUNT_W'(WORD_BITS))
      else $error("flush response count out of range");

endmodule

bind huffman_table_encoder_bit_packer hteb_checker u_hteb_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hteb_pkg::*;

   localparam int          MAX_CODE      = 32;
   localparam int          TABLE_SIZE    = 256;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          LONG_HOLD     = 300;
   localparam int          LIMIT_CYCLES  = 500000;
   localparam logic [1:0]  ACT_UNUSED    = 2'd3;
   localparam logic        PACK_MSB_DOWN = 1'b0;
   localparam logic        PACK_LSB_UP   = 1'b1;

   typedef struct {
      logic [1:0]  action;
      logic [7:0]  symbol;
      logic [31:0] code_value;
      logic [5:0]  code_length;
   } huff_req_type;

   typedef struct {
      logic [31:0] packed_word;
      logic [5:0]  bit_count;
      logic        no_code_error;
      logic        last_word;
   } packed_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_symbol = '0;
   logic [31:0] req_code_value = '0;
   logic [5:0]  req_code_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_packed_word;
   logic [5:0]  rsp_bit_count;
   logic        rsp_no_code_error;
   logic        rsp_last_word;

   huffman_table_encoder_bit_packer u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_symbol        (req_symbol),
      .req_code_value    (req_code_value),
      .req_code_length   (req_code_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packed_word   (rsp_packed_word),
      .rsp_bit_count     (rsp_bit_count),
      .rsp_no_code_error (rsp_no_code_error),
      .rsp_last_word     (rsp_last_word)
   );

   // shadow state of the encoder
   logic [31:0] shadow_code [TABLE_SIZE];
   logic [5:0]  shadow_len  [TABLE_SIZE];
   logic [31:0] shadow_acc = '0;
   int          shadow_fill = 0;
   logic        shadow_order = PACK_MSB_DOWN;

   huff_req_type   symbol_stream [$];
   packed_rsp_type expected_words [$];

   int   mismatches = 0;
   int   cycle_count = 0;
   bit   no_idle = 1'b0;
   int   long_holds_asked = 0;
   int   long_holds_seen = 0;

   bit           tx_busy;
   int           tx_gap = 0;
   huff_req_type tx_item;
   int           rx_stall = 0;
   logic         rx_ready_next;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         shadow_code[i] = '0;
         shadow_len[i]  = '0;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // advance the shadow encoder by one accepted transaction
   task automatic pack_symbol_item(input huff_req_type it);
      packed_rsp_type r;
      logic [5:0]  len;
      logic [31:0] code;
      logic [31:0] rev;
      logic [63:0] w;
      int          total;
      case (it.action)
         ACT_LOAD: begin
            len = (it.code_length > MAX_CODE) ? 6'(MAX_CODE) : it.code_length;
            shadow_len[it.symbol]  = len;
            shadow_code[it.symbol] = it.code_value & 32'((64'd1 << len) - 64'd1);
         end
         ACT_ENCODE: begin
            len  = shadow_len[it.symbol];
            code = shadow_code[it.symbol];
            if (len == 0) begin
               r = '{32'd0, 6'd0, 1'b1, 1'b0};
               expected_words.push_back(r);
            end else begin
               total = shadow_fill + len;
               if (shadow_order == PACK_MSB_DOWN) begin
                  w = {shadow_acc, 32'd0} | ({32'd0, code} << (64 - total));
                  if (total >= 32) begin
                     r = '{w[63:32], 6'd32, 1'b0, 1'b0};
                     expected_words.push_back(r);
                     shadow_acc  = w[31:0];
                     shadow_fill = total - 32;
                  end else begin
                     shadow_acc  = w[63:32];
                     shadow_fill = total;
                  end
               end else begin
                  // root bit of the code lands at the lowest free position
                  rev = '0;
                  for (int i = 0; i < len; i++)
                     rev[len - 1 - i] = code[i];
                  w = {32'd0, shadow_acc} | ({32'd0, rev} << shadow_fill);
                  if (total >= 32) begin
                     r = '{w[31:0], 6'd32, 1'b0, 1'b0};
                     expected_words.push_back(r);
                     shadow_acc  = w[63:32];
                     shadow_fill = total - 32;
                  end else begin
                     shadow_acc  = w[31:0];
                     shadow_fill = total;
                  end
               end
            end
         end
         ACT_FLUSH: begin
            r = '{shadow_acc, 6'(shadow_fill), 1'b0, 1'b1};
            expected_words.push_back(r);
            shadow_acc  = '0;
            shadow_fill = 0;
         end
         default: ;
      endcase
   endtask

   task automatic check_word();
      packed_rsp_type exp_r;
      if (expected_words.size() == 0) begin
         $error("unexpected result transaction: word %h count %0d", rsp_packed_word,
                rsp_bit_count);
         mismatches++;
      end else begin
         exp_r = expected_words.pop_front();
         if (rsp_packed_word !== exp_r.packed_word) begin
            $error("packed_word expected %h actual %h", exp_r.packed_word, rsp_packed_word);
            mismatches++;
         end
         if (rsp_bit_count !== exp_r.bit_count) begin
            $error("bit_count expected %0d actual %0d", exp_r.bit_count, rsp_bit_count);
            mismatches++;
         end
         if (rsp_no_code_error !== exp_r.no_code_error) begin
            $error("no_code_error expected %b actual %b", exp_r.no_code_error,
                   rsp_no_code_error);
            mismatches++;
         end
         if (rsp_last_word !== exp_r.last_word) begin
            $error("last_word expected %b actual %b", exp_r.last_word, rsp_last_word);
            mismatches++;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         tx_busy = req_valid;
         if (req_valid && req_ready) begin
            pack_symbol_item(tx_item);
            tx_busy = 1'b0;
         end
         if (!tx_busy) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (symbol_stream.size() > 0) begin
               tx_item = symbol_stream.pop_front();
               req_action      <= tx_item.action;
               req_symbol      <= tx_item.symbol;
               req_code_value  <= tx_item.code_value;
               req_code_length <= tx_item.code_length;
               tx_busy = 1'b1;
               tx_gap  = idle_length();
            end
         end
         req_valid <= tx_busy;
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_word();
         if (long_holds_seen != long_holds_asked) begin
            long_holds_seen++;
            rx_stall = LONG_HOLD;
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rx_ready_next = 1'b0;
         end else begin
            rx_ready_next = 1'b1;
            rx_stall = idle_length();
         end
         rsp_ready <= rx_ready_next;
      end
   end

   task automatic push_item(input logic [1:0] act, input logic [7:0] sym,
                            input logic [31:0] cval, input logic [5:0] clen);
      huff_req_type it;
      it = '{act, sym, cval, clen};
      symbol_stream.push_back(it);
   endtask

   task automatic wait_drained();
      // tx_busy follows the driver's own view, so no edge race with req_valid
      while (symbol_stream.size() != 0 || tx_busy || expected_words.size() != 0)
         @(posedge clock);
      // loads and short encodes may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_pack_order(input logic order);
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= order;
      shadow_order = order;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      int   issued;
      int   r;
      logic [7:0]  sym;
      logic [5:0]  clen;
      issued = 0;
      while (issued < count) begin
         r   = $urandom_range(0, 99);
         sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 15));
         if (r < 20) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               clen = 6'd0;
            else if (r < 18)
               clen = 6'($urandom_range(33, 63));
            else if (r < 35)
               clen = 6'($urandom_range(13, 32));
            else
               clen = 6'($urandom_range(1, 12));
            push_item(ACT_LOAD, sym, $urandom, clen);
            issued++;
         end else if (r < 88) begin
            push_item(ACT_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
            issued++;
         end else if (r < 96) begin
            push_item(ACT_FLUSH, sym, $urandom, 6'($urandom_range(0, 63)));
            issued++;
         end else begin
            push_item(ACT_UNUSED, sym, $urandom, 6'($urandom_range(0, 63)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_pack_order(PACK_MSB_DOWN);

      // corner cases with msb-first packing
      push_item(ACT_ENCODE, 8'd5,   32'h0,         6'd0);   // no code after reset
      push_item(ACT_FLUSH,  8'd0,   32'h0,         6'd0);   // flush of empty word
      push_item(ACT_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);
      push_item(ACT_LOAD,   8'd255, 32'h0000_0001, 6'd1);
      push_item(ACT_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd63);  // overlong length
      push_item(ACT_LOAD,   8'd2,   32'hABCD_EF5A, 6'd5);   // high code bits dropped
      push_item(ACT_LOAD,   8'd3,   32'h0000_02AA, 6'd10);
      push_item(ACT_LOAD,   8'd4,   32'h0000_0000, 6'd7);
      push_item(ACT_ENCODE, 8'd255, 32'h0,         6'd0);
      push_item(ACT_ENCODE, 8'd0,   32'h0,         6'd0);   // crosses word boundary
      push_item(ACT_ENCODE, 8'd2,   32'h0,         6'd0);
      push_item(ACT_ENCODE, 8'd3,   32'h0,         6'd0);
      push_item(ACT_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
      push_item(ACT_ENCODE, 8'd1,   32'h0,         6'd0);
      push_item(ACT_FLUSH,  8'd0,   32'h0,         6'd0);
      push_item(ACT_ENCODE, 8'd0,   32'h0,         6'd0);   // exact full word
      push_item(ACT_LOAD,   8'd0,   32'h1234_5678, 6'd0);   // remove code
      push_item(ACT_ENCODE, 8'd0,   32'h0,         6'd0);
      push_item(ACT_ENCODE, 8'd4,   32'h0,         6'd0);
      push_item(ACT_ENCODE, 8'd3,   32'h0,         6'd0);
      wait_drained();

      // switch to lsb-first with a partial word held
      set_pack_order(PACK_LSB_UP);
      push_item(ACT_ENCODE, 8'd3,   32'h0, 6'd0);
      push_item(ACT_ENCODE, 8'd2,   32'h0, 6'd0);
      push_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
      push_item(ACT_ENCODE, 8'd1,   32'h0, 6'd0);
      push_item(ACT_FLUSH,  8'd0,   32'h0, 6'd0);
      push_item(ACT_ENCODE, 8'd1,   32'h0, 6'd0);
      push_item(ACT_FLUSH,  8'd0,   32'h0, 6'd0);
      wait_drained();

      // random traffic, receiver blocked at first so the pipe backs up
      set_pack_order(PACK_MSB_DOWN);
      long_holds_asked++;
      queue_random(90);
      wait_drained();

      // back to back, no idle cycles either side
      set_pack_order(PACK_LSB_UP);
      no_idle = 1'b1;
      queue_random(90);
      wait_drained();
      no_idle = 1'b0;

      // sender pauses mid-stream until the output side has caught up
      set_pack_order(PACK_MSB_DOWN);
      queue_random(45);
      wait_drained();
      queue_random(45);
      wait_drained();

      set_pack_order(PACK_LSB_UP);
      queue_random(90);
      wait_drained();

      if (expected_words.size() != 0) begin
         $error("%0d expected result transactions never arrived", expected_words.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("huffman_table_encoder_bit_packer test passed");
      else
         $display("huffman_table_encoder_bit_packer test failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("huffman_table_encoder_bit_packer test failed");
      $finish;
   end

endmodule

FILE: filelist.f
sv/hteb_pkg.sv
sv/hteb_code_table.sv
sv/huffman_table_encoder_bit_packer.sv
sv/hteb_checker.sv
tb/tb_top.sv
